FILE: hdl/erv_pkg.sv
// Package for the Euler rotation vertex transform.
// Holds item types, fixed-point widths and polynomial constants.
// No dependencies.
`timescale 1ns / 1ps
package erv_pkg;
  localparam int CoordWidth = 32;
  localparam int AngleWidth = 16;
  localparam int CoefWidth = 18;
  localparam int Cf = CoefWidth - 2;

  localparam logic signed [63:0] C1 = 64'sd1686629713;
  localparam logic signed [63:0] C3 = 64'sd693598668;
  localparam logic signed [63:0] C5 = 64'sd85569306;
  localparam logic signed [63:0] C7 = 64'sd5026988;
  localparam logic signed [63:0] C9 = 64'sd172276;

  typedef struct packed {
    logic                         mode;
    logic [AngleWidth-1:0]        angle_alpha;
    logic [AngleWidth-1:0]        angle_beta;
    logic [AngleWidth-1:0]        angle_gamma;
    logic signed [CoordWidth-1:0] in_x;
    logic signed [CoordWidth-1:0] in_y;
    logic signed [CoordWidth-1:0] in_z;
    logic signed [CoordWidth-1:0] in_w;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] out_x;
    logic signed [CoordWidth-1:0] out_y;
    logic signed [CoordWidth-1:0] out_z;
    logic signed [CoordWidth-1:0] out_w;
  } out_item_t;
endpackage

FILE: hdl/euler_rotate_vertex_transform.sv
// Euler rotation vertex transform, top level.
// Uses erv_pkg for item types and constants.
//
// Usage: items enter on in_valid/in_ready and carry mode plus payload.
// A set-rotation item (mode 0) builds a 3x3 rotation matrix from three
// binary angles and stores it; it gives no result. A transform item
// (mode 1) multiplies the vertex, as a row vector, by the stored matrix
// and gives one result on out_valid/out_ready with x, y, z saturated
// and w passed through.
// Timing: one shared 32x32 signed multiplier is sequenced by step
// counters, one product per cycle. A transform item takes 9 products,
// then loads the output register from the done state. A set-rotation
// item works through six sines (7 steps each) and 14 matrix steps.
// The block is not ready while it works on an item. While a result waits
// on a stalled receiver, the block still takes set-rotation items and one
// more transform item; that transform result then holds in its final step
// until the register frees.
// Reset: the matrix returns to identity, the sequencer to idle and the
// output register empties.
`timescale 1ns / 1ps
module euler_rotate_vertex_transform (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  erv_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output erv_pkg::out_item_t  out_item
);
  localparam int Cw = erv_pkg::CoefWidth;
  localparam int Cf = erv_pkg::Cf;
  localparam int Aw = erv_pkg::AngleWidth;
  localparam int Kw = erv_pkg::CoordWidth;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SIN  = 5'b00010,
    S_MAT  = 5'b00100,
    S_XF   = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;
  erv_pkg::in_item_t item;
  logic signed [Cw-1:0] coefs [9];
  logic signed [Cw-1:0] trig [6];   // sa ca sb cb sg cg
  logic signed [Cw-1:0] sab, cab;
  logic [2:0] tsel;                 // which sine
  logic [2:0] step;                 // step within a sine
  logic [4:0] mstep;                // matrix step
  logic [1:0] ri, cj;               // transform row and column
  logic signed [63:0] sx, sz, ss;   // sine working values
  logic [1:0] quad;
  logic signed [63:0] acc, xsum;
  logic signed [Kw-1:0] rx, ry, rz;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic res_load;

  // Shared multiplier
  assign prod = mul_a * mul_b;

  // Angle select for the current sine/cosine
  logic [Aw-1:0] ang;
  always_comb begin
    unique case (tsel[2:1])
      2'd0:    ang = item.angle_alpha;
      2'd1:    ang = item.angle_beta;
      default: ang = item.angle_gamma;
    endcase
    if (tsel[0]) ang = ang + Aw'(1 << (Aw - 2));
  end

  function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int k);
    logic signed [63:0] t;
    t = v + (64'sd1 <<< (k - 1));
    return t >>> k;
  endfunction

  function automatic logic signed [Cw-1:0] satc(input logic signed [63:0] v);
    logic signed [63:0] hi;
    hi = (64'sd1 <<< (Cw - 1)) - 1;
    if (v > hi) return Cw'(hi);
    else if (v < -hi - 1) return Cw'(-hi - 1);
    else return Cw'(v);
  endfunction

  function automatic logic signed [Kw-1:0] satk(input logic signed [63:0] v);
    logic signed [63:0] hi;
    hi = (64'sd1 <<< (Kw - 1)) - 1;
    if (v > hi) return Kw'(hi);
    else if (v < -hi - 1) return Kw'(-hi - 1);
    else return Kw'(v);
  endfunction

  // Matrix step: product operands and coefficient target (0..13)
  logic signed [Cw-1:0] ma, mb;
  always_comb begin
    ma = trig[3]; mb = trig[5];
    unique case (mstep)
      5'd0:  begin ma = trig[0]; mb = trig[2]; end   // sab
      5'd1:  begin ma = trig[1]; mb = trig[2]; end   // cab
      5'd2:  begin ma = trig[3]; mb = trig[5]; end   // cb*cg
      5'd3:  begin ma = sab;     mb = trig[5]; end
      5'd4:  begin ma = trig[1]; mb = trig[4]; end   // - ca*sg
      5'd5:  begin ma = cab;     mb = trig[5]; end
      5'd6:  begin ma = trig[0]; mb = trig[4]; end   // + sa*sg
      5'd7:  begin ma = trig[3]; mb = trig[4]; end   // cb*sg
      5'd8:  begin ma = sab;     mb = trig[4]; end
      5'd9:  begin ma = trig[1]; mb = trig[5]; end   // + ca*cg
      5'd10: begin ma = cab;     mb = trig[4]; end
      5'd11: begin ma = trig[0]; mb = trig[5]; end   // - sa*cg
      5'd12: begin ma = trig[0]; mb = trig[3]; end   // sa*cb
      5'd13: begin ma = trig[1]; mb = trig[3]; end   // ca*cb
      default: ;
    endcase
  end

  // Transform step: full coordinate times coefficient
  logic signed [Kw-1:0] vin;
  always_comb begin
    unique case (ri)
      2'd0:    vin = item.in_x;
      2'd1:    vin = item.in_y;
      default: vin = item.in_z;
    endcase
  end

  // Multiplier operand select
  logic signed [Cw-1:0] cm;
  always_comb begin
    cm = coefs[4'(ri) * 4'd3 + 4'(cj)];
    mul_a = '0; mul_b = '0;
    unique case (state)
      S_SIN: begin
        unique case (step)
          3'd1:    begin mul_a = 32'(sx); mul_b = 32'(sx); end
          3'd2, 3'd3, 3'd4, 3'd5: begin mul_a = 32'(ss); mul_b = 32'(sz); end
          default: begin mul_a = 32'(ss); mul_b = 32'(sx); end
        endcase
      end
      S_MAT: begin mul_a = 32'(ma); mul_b = 32'(mb); end
      S_XF:  begin mul_a = vin; mul_b = 32'(cm); end
      default: ;
    endcase
  end

  // Column sum of the transform
  assign xsum = ((ri == 2'd0) ? 64'sd0 : acc) + prod;

  logic signed [63:0] r6, sv;
  logic [Aw-3:0] rr;
  logic [Aw-2:0] rq;
  always_comb begin
    rr = ang[Aw-3:0];
    rq = ang[Aw-2] ? ((Aw-1)'(1 << (Aw - 2)) - (Aw-1)'(rr)) : (Aw-1)'(rr);
    r6 = rnd(prod, 60 - Cf);
    sv = quad[1] ? -r6 : r6;
  end

  logic signed [63:0] ssum;
  always_comb begin
    unique case (step)
      3'd2:    ssum = erv_pkg::C7 - (prod >>> 30);
      3'd3:    ssum = erv_pkg::C5 - (prod >>> 30);
      3'd4:    ssum = erv_pkg::C3 - (prod >>> 30);
      default: ssum = erv_pkg::C1 - (prod >>> 30);
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign res_load = (state == S_DONE) && (!out_valid || out_ready);

  // Hold the result until taken, load a new one when the register frees
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < 9; i++)
        coefs[i] <= (i % 4 == 0) ? Cw'(1 << Cf) : '0;
      tsel <= '0; step <= '0; mstep <= '0;
      ri <= '0; cj <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          item <= in_item;
          tsel <= '0; step <= '0; mstep <= '0;
          ri <= '0; cj <= '0;
          state <= in_item.mode ? S_XF : S_SIN;
        end
        S_SIN: begin
          unique case (step)
            3'd0: begin
              quad <= ang[Aw-1:Aw-2];
              sx <= 64'(rq) <<< (32 - Aw);
              ss <= erv_pkg::C9;
              step <= 3'd1;
            end
            3'd1: begin sz <= prod >>> 30; step <= 3'd2; end
            3'd2, 3'd3, 3'd4, 3'd5: begin ss <= ssum; step <= step + 3'd1; end
            default: begin
              trig[tsel] <= Cw'(sv);
              step <= '0;
              if (tsel == 3'd5) begin state <= S_MAT; mstep <= '0; end
              else tsel <= tsel + 3'd1;
            end
          endcase
        end
        S_MAT: begin
          mstep <= mstep + 5'd1;
          unique case (mstep)
            5'd0:  sab <= Cw'(rnd(prod, Cf));
            5'd1:  cab <= Cw'(rnd(prod, Cf));
            5'd2:  coefs[0] <= satc(rnd(prod, Cf));
            5'd3, 5'd5, 5'd8, 5'd10: acc <= prod;
            5'd4:  coefs[1] <= satc(rnd(acc - prod, Cf));
            5'd6:  coefs[2] <= satc(rnd(acc + prod, Cf));
            5'd7:  coefs[3] <= satc(rnd(prod, Cf));
            5'd9:  coefs[4] <= satc(rnd(acc + prod, Cf));
            5'd11: coefs[5] <= satc(rnd(acc - prod, Cf));
            5'd12: coefs[7] <= satc(rnd(prod, Cf));
            default: begin
              coefs[8] <= satc(rnd(prod, Cf));
              coefs[6] <= satc(-64'(trig[2]));
              state <= S_IDLE;
            end
          endcase
        end
        S_XF: begin
          // Advance down a column, finish it on the last row
          if (ri == 2'd2) begin
            ri <= 2'd0;
            unique case (cj)
              2'd0:    rx <= satk(rnd(xsum, Cf));
              2'd1:    ry <= satk(rnd(xsum, Cf));
              default: rz <= satk(rnd(xsum, Cf));
            endcase
            if (cj == 2'd2) state <= S_DONE;
            else cj <= cj + 2'd1;
          end else begin
            acc <= xsum;
            ri <= ri + 2'd1;
          end
        end
        S_DONE: if (res_load) begin
          out_item.out_x <= rx;
          out_item.out_y <= ry;
          out_item.out_z <= rz;
          out_item.out_w <= item.in_w;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
